@@ rtl/lrk_pkg.sv @@
// Shared types and constants for the LRU-K replacement directory.
// Holds item payload structs, the sequencer state type and configuration register codes.
// No dependencies; the directory, the min tracker and the testbench import this package.
`timescale 1ns / 1ps
`default_nettype none

package lrk_pkg;

    // Fixed field widths of the item payloads and the configuration port.
    localparam int KEY_W      = 32;
    localparam int SLOT_IDX_W = 4;
    localparam int CAP_W      = 5;
    localparam int DEPTH_W    = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH    = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [CAP_W-1:0]   CAP_RESET   = 5'd16;
    localparam logic [DEPTH_W-1:0] DEPTH_RESET = 3'd2;

    // Input item: one page access.
    typedef struct packed {
        logic signed [KEY_W-1:0] access_key;
    } t_req;

    // Result item: placement of the accessed page.
    typedef struct packed {
        logic                    hit;
        logic [SLOT_IDX_W-1:0]   slot_index;
        logic                    evicted;
        logic signed [KEY_W-1:0] evicted_key;
    } t_rsp;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN_A,
        ST_DRAIN_A,
        ST_PICK,
        ST_SCAN_B,
        ST_DRAIN_B,
        ST_COMMIT
    } t_state;

    // Control of the running-minimum tracker.
    typedef struct packed {
        logic clear;
        logic load;
    } t_trk_ctl;

endpackage

`default_nettype wire

@@ rtl/lrk_chan_if.sv @@
// Valid/ready channel carrying one item payload of a chosen struct type.
// Depends on nothing; the payload types come from lrk_pkg at instantiation.
`timescale 1ns / 1ps
`default_nettype none

interface lrk_chan_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/lru_k_replacement_policy_unit.sv @@
// Top level of the LRU-K replacement directory: key and history memories and sequencer.
// Depends on lrk_pkg, lrk_chan_if and lrk_min_track.
//
//   Port        Dir  Handshake      Payload
//   i_req       in   valid/ready    access_key
//   o_rsp       out  valid/ready    hit, slot_index, evicted, evicted_key
//   i_cfg_*     in   write enable   register index, write data
//
// An item takes one scan of the filled slots when it hits, fills a free slot or finds a
// page with fewer than K accesses (none when the directory is empty), and two otherwise.
// Each scan reads one slot a cycle from the key and history memories through a single
// stamp comparator. Reset is synchronous and needs no clearing pass. A new item is
// taken while a result still waits; the sequencer only stalls at its last step when
// the output register is still occupied.
`timescale 1ns / 1ps
`default_nettype none

module lru_k_replacement_policy_unit
    import lrk_pkg::*;
#(
    parameter int SLOTS      = 16,
    parameter int MAX_K      = 4,
    parameter int STAMP_BITS = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    lrk_chan_if.sink                   i_req,
    lrk_chan_if.source                 o_rsp
);

    localparam int SW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int FW   = $clog2(SLOTS + 1);
    localparam int CAPW = (FW > CAP_W) ? FW : CAP_W;
    localparam int PW   = (MAX_K > 1) ? $clog2(MAX_K) : 1;
    localparam int KW   = $clog2(MAX_K + 1);
    localparam int DPW  = (KW > DEPTH_W) ? KW : DEPTH_W;
    localparam int SUMW = $clog2(2 * MAX_K) + 1;

    // Clamp a capacity code to 1..SLOTS.
    function automatic logic [FW-1:0] clamp_cap(input logic [CAP_W-1:0] v);
        logic [CAPW-1:0] e;
        e = CAPW'(v);
        if (e == '0) begin
            return FW'(1);
        end else if (e > CAPW'(SLOTS)) begin
            return FW'(SLOTS);
        end
        return FW'(e);
    endfunction

    // Clamp a depth code to 1..MAX_K.
    function automatic logic [KW-1:0] clamp_depth(input logic [DEPTH_W-1:0] v);
        logic [DPW-1:0] e;
        e = DPW'(v);
        if (e == '0) begin
            return KW'(1);
        end else if (e > DPW'(MAX_K)) begin
            return KW'(MAX_K);
        end
        return KW'(e);
    endfunction

    // Ring position of the K-th most recent stamp, given the newest position.
    function automatic logic [PW-1:0] kth_pos(input logic [PW-1:0] head,
                                              input logic [KW-1:0] k);
        logic [SUMW-1:0] sum;
        sum = SUMW'(head) + SUMW'(MAX_K) - SUMW'(k) + SUMW'(1);
        if (sum >= SUMW'(MAX_K)) begin
            sum = sum - SUMW'(MAX_K);
        end
        return PW'(sum);
    endfunction

    // Configuration and directory control state.
    logic [CAP_W-1:0]      r_cap;
    logic [DEPTH_W-1:0]    r_depth;
    logic [FW-1:0]         r_filled;
    logic [STAMP_BITS-1:0] r_stamp;
    logic [KW-1:0]         r_cnt  [SLOTS];
    logic [PW-1:0]         r_head [SLOTS];

    // Key memory and per-slot history rings.
    logic [KEY_W-1:0]      m_key  [SLOTS];
    logic [STAMP_BITS-1:0] m_hist [SLOTS][MAX_K];

    // Sequencer and scan pipeline.
    t_state                r_state;
    t_state                n_state;
    logic [SW-1:0]         r_idx;
    logic [KEY_W-1:0]      r_key;
    logic                  r_hit;
    logic [SW-1:0]         r_hit_idx;
    logic                  r_chk_v;
    logic                  r_chk_pass_b;
    logic                  r_chk_young;
    logic [SW-1:0]         r_chk_idx;
    logic [KEY_W-1:0]      r_key_rd;
    logic [STAMP_BITS-1:0] r_hist_rd;

    // Output register.
    logic                  r_out_valid;
    t_rsp                  r_out;

    logic [FW-1:0]         eff_cap;
    logic [KW-1:0]         eff_k;
    logic [FW-1:0]         new_cap;
    logic                  accept;
    logic                  issue;
    logic                  last_issue;
    logic                  go_b;
    logic                  out_free;
    logic                  commit_go;
    logic [PW-1:0]         rd_pos;
    t_trk_ctl              trk_ctl;
    logic                  trk_found;
    logic [SW-1:0]         trk_idx;
    logic [KEY_W-1:0]      trk_key;
    logic [SW-1:0]         c_slot;
    logic                  c_fill;
    logic                  c_evict;
    logic [KEY_W-1:0]      c_evkey;
    logic [PW-1:0]         c_head;
    logic [KW-1:0]         c_cnt;
    logic [PW-1:0]         head_cur;
    logic [KW-1:0]         cnt_cur;
    logic [SW+SLOT_IDX_W-1:0] slot_ext;

    assign eff_cap = clamp_cap(r_cap);
    assign eff_k   = clamp_depth(r_depth);
    assign new_cap = clamp_cap(i_cfg_data[CAP_W-1:0]);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = (r_filled == '0) ? ST_PICK : ST_SCAN_A;
                end
            end
            ST_SCAN_A: begin
                if (last_issue) begin
                    n_state = ST_DRAIN_A;
                end
            end
            ST_DRAIN_A: begin
                n_state = ST_PICK;
            end
            ST_PICK: begin
                n_state = go_b ? ST_SCAN_B : ST_COMMIT;
            end
            ST_SCAN_B: begin
                if (last_issue) begin
                    n_state = ST_DRAIN_B;
                end
            end
            ST_DRAIN_B: begin
                n_state = ST_COMMIT;
            end
            ST_COMMIT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        i_req.ready = (r_state == ST_IDLE);
        issue       = (r_state == ST_SCAN_A) || (r_state == ST_SCAN_B);
        go_b        = (r_state == ST_PICK) && !r_hit && !(r_filled < eff_cap) && !trk_found;
        commit_go   = (r_state == ST_COMMIT) && out_free;
    end

    assign accept     = i_req.valid && i_req.ready;
    assign last_issue = ((FW'(r_idx) + FW'(1)) == r_filled);
    assign out_free   = !r_out_valid || o_rsp.ready;

    // Pass A reads the newest stamp, pass B the K-th most recent one.
    assign rd_pos = (r_state == ST_SCAN_B) ? kth_pos(r_head[r_idx], eff_k) : r_head[r_idx];

    // Registered memory reads, one slot a cycle.
    always_ff @(posedge i_clk) begin
        r_key_rd  <= m_key[r_idx];
        r_hist_rd <= m_hist[r_idx][rd_pos];
    end

    // Scan pipeline tags that travel with the read data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chk_v <= 1'b0;
        end else begin
            r_chk_v <= issue;
        end
        r_chk_pass_b <= (r_state == ST_SCAN_B);
        r_chk_idx    <= r_idx;
        r_chk_young  <= (r_cnt[r_idx] < eff_k);
    end

    // Shared comparator: young pages in pass A, all pages in pass B.
    always_comb begin
        trk_ctl.clear = accept || go_b;
        trk_ctl.load  = r_chk_v && (r_chk_pass_b || r_chk_young);
    end

    lrk_min_track #(
        .STAMP_BITS(STAMP_BITS),
        .SW        (SW)
    ) u_min_track (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (trk_ctl),
        .i_stamp(r_hist_rd),
        .i_idx  (r_chk_idx),
        .i_key  (r_key_rd),
        .o_found(trk_found),
        .o_idx  (trk_idx),
        .o_key  (trk_key)
    );

    // Placement decision for the current item.
    always_comb begin
        c_fill  = 1'b0;
        c_evict = 1'b0;
        c_evkey = '0;
        if (r_hit) begin
            c_slot = r_hit_idx;
        end else if (r_filled < eff_cap) begin
            c_slot = r_filled[SW-1:0];
            c_fill = 1'b1;
        end else begin
            c_slot  = trk_idx;
            c_evict = 1'b1;
            c_evkey = trk_key;
        end
        head_cur = r_head[c_slot];
        cnt_cur  = r_cnt[c_slot];
        c_head   = (head_cur == PW'(MAX_K - 1)) ? '0 : head_cur + 1'b1;
        if (!r_hit) begin
            c_cnt = KW'(1);
        end else if (cnt_cur < KW'(MAX_K)) begin
            c_cnt = cnt_cur + 1'b1;
        end else begin
            c_cnt = cnt_cur;
        end
        slot_ext = {{SLOT_IDX_W{1'b0}}, c_slot};
    end

    // Memory writes at commit.
    always_ff @(posedge i_clk) begin
        if (commit_go) begin
            if (!r_hit) begin
                m_key[c_slot] <= r_key;
            end
            m_hist[c_slot][c_head] <= r_stamp;
        end
    end

    // Sequencer, directory and configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_hit       <= 1'b0;
            r_filled    <= '0;
            r_stamp     <= '0;
            r_cap       <= CAP_RESET;
            r_depth     <= DEPTH_RESET;
            r_out_valid <= 1'b0;
            for (int s = 0; s < SLOTS; s++) begin
                r_cnt[s]  <= '0;
                r_head[s] <= '0;
            end
        end else begin
            r_state <= n_state;

            // Item capture and stamp advance.
            if (accept) begin
                r_key <= i_req.data.access_key;
                r_hit <= 1'b0;
                r_idx <= '0;
                if (r_stamp != '1) begin
                    r_stamp <= r_stamp + 1'b1;
                end
            end else if (go_b) begin
                r_idx <= '0;
            end else if (issue && !last_issue) begin
                r_idx <= r_idx + 1'b1;
            end

            // First matching key in pass A.
            if (r_chk_v && !r_chk_pass_b && !r_hit && (r_key_rd == r_key)) begin
                r_hit     <= 1'b1;
                r_hit_idx <= r_chk_idx;
            end

            // Commit the access into the directory.
            if (commit_go) begin
                r_cnt[c_slot]  <= c_cnt;
                r_head[c_slot] <= c_head;
                if (c_fill) begin
                    r_filled <= r_filled + 1'b1;
                end
            end

            // Result register.
            if (commit_go) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end

            // Configuration writes; lowering capacity drops pages beyond it.
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_CAPACITY: begin
                        r_cap <= i_cfg_data[CAP_W-1:0];
                        if (r_filled > new_cap) begin
                            r_filled <= new_cap;
                        end
                    end
                    REG_DEPTH: begin
                        r_depth <= i_cfg_data[DEPTH_W-1:0];
                    end
                    default: begin
                        r_depth <= r_depth;
                    end
                endcase
            end
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (commit_go) begin
            r_out.hit         <= r_hit;
            r_out.slot_index  <= slot_ext[SLOT_IDX_W-1:0];
            r_out.evicted     <= c_evict;
            r_out.evicted_key <= c_evkey;
        end
    end

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

    // Checks on directory and result consistency.
    ap_fill_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_filled <= eff_cap)
        else $error("filled slot count exceeds capacity");

    ap_evkey_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && !o_rsp.data.evicted |-> o_rsp.data.evicted_key == '0)
        else $error("evicted key nonzero without eviction");

    ap_evict_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.data.evicted |-> !o_rsp.data.hit)
        else $error("eviction reported on a hit");

    ap_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_state != ST_IDLE)
        else $error("sequencer idle right after taking an item");

    ap_commit_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit_go |=> r_out_valid)
        else $error("committed item did not reach the output register");

endmodule

`default_nettype wire

@@ rtl/lrk_min_track.sv @@
// Shared stamp comparator with running minimum for the victim search.
// Keeps the oldest stamp seen since the last clear, with its slot and key.
// Depends on lrk_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lrk_min_track
    import lrk_pkg::*;
#(
    parameter int STAMP_BITS = 32,
    parameter int SW         = 4
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_trk_ctl              i_ctl,
    input  wire logic [STAMP_BITS-1:0] i_stamp,
    input  wire logic [SW-1:0]         i_idx,
    input  wire logic [KEY_W-1:0]      i_key,
    output logic                       o_found,
    output logic [SW-1:0]              o_idx,
    output logic [KEY_W-1:0]           o_key
);

    logic                  r_found;
    logic [STAMP_BITS-1:0] r_best_stamp;
    logic [SW-1:0]         r_best_idx;
    logic [KEY_W-1:0]      r_best_key;
    logic                  take;

    // A strictly older stamp replaces the best, so ties stay with the lowest slot.
    assign take = i_ctl.load && (!r_found || (i_stamp < r_best_stamp));

    // Found flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_ctl.clear) begin
            r_found <= 1'b0;
        end else if (take) begin
            r_found <= 1'b1;
        end
    end

    // Best candidate payload.
    always_ff @(posedge i_clk) begin
        if (!i_ctl.clear && take) begin
            r_best_stamp <= i_stamp;
            r_best_idx   <= i_idx;
            r_best_key   <= i_key;
        end
    end

    assign o_found = r_found;
    assign o_idx   = r_best_idx;
    assign o_key   = r_best_key;

endmodule

`default_nettype wire

@@ dv/tb_lru_k_replacement_policy_unit.sv @@
// Self-checking testbench for the LRU-K replacement directory.
// Uses lrk_pkg, lrk_chan_if and the lru_k_replacement_policy_unit top level from rtl.
// Drives access keys in bursts, stalls the result side and checks every placement.
`timescale 1ns / 1ps

module tb_lru_k_replacement_policy_unit;
    import lrk_pkg::*;

    localparam int N_SLOTS = 16;
    localparam int N_HIST  = 4;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    lrk_chan_if #(.T(t_req)) req_if ();
    lrk_chan_if #(.T(t_rsp)) rsp_if ();

    lru_k_replacement_policy_unit u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_if),
        .o_rsp      (rsp_if)
    );

    // Pending access keys, expected placements and the error tally.
    logic [KEY_W-1:0] access_q[$];
    t_rsp             placement_q[$];
    int               err_cnt = 0;
    bit               req_fire = 1'b0;

    // Directory mirror: keys, stamp histories (newest first) and use counts.
    logic [KEY_W-1:0]   pg_key[N_SLOTS];
    logic [KEY_W-1:0]   pg_stamp[N_SLOTS][N_HIST];
    logic [2:0]         pg_uses[N_SLOTS] = '{default: '0};
    int unsigned        pg_filled = 0;
    logic [KEY_W-1:0]   stamp_now = '0;
    logic [CAP_W-1:0]   reg_cap   = CAP_RESET;
    logic [DEPTH_W-1:0] reg_depth = DEPTH_RESET;

    // Sender and receiver pacing state.
    int burst_left = 0;
    int gap_left   = 0;
    int stall_left = 0;
    int rx_mode    = 0;
    int rx_span    = 0;

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Out-of-range capacity and depth settings clamp to the legal range.
    function automatic int unsigned cap_eff();
        if (reg_cap == 0) return 1;
        if (reg_cap > N_SLOTS) return N_SLOTS;
        return 32'(reg_cap);
    endfunction

    function automatic int unsigned depth_eff();
        if (reg_depth == 0) return 1;
        if (reg_depth > N_HIST) return N_HIST;
        return 32'(reg_depth);
    endfunction

    // Mirror a register write; lowering the capacity forgets the dropped slots.
    task automatic apply_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                   input logic [CFG_DATA_W-1:0] data);
        if (idx == REG_CAPACITY) begin
            reg_cap = data[CAP_W-1:0];
            if (pg_filled > cap_eff()) pg_filled = cap_eff();
        end else if (idx == REG_DEPTH) begin
            reg_depth = data[DEPTH_W-1:0];
        end
    endtask

    // Work out where an access lands and update the mirror.
    task automatic predict_placement(input logic [KEY_W-1:0] key, output t_rsp res);
        int unsigned      cap, k, n, slot, best;
        bit               hit, found;
        logic [KEY_W-1:0] best_t, t;
        cap   = cap_eff();
        k     = depth_eff();
        n     = (pg_filled < cap) ? pg_filled : cap;
        slot  = 0;
        hit   = 1'b0;
        res   = '0;
        // The stamp counter saturates at its maximum.
        if (stamp_now != '1) stamp_now = stamp_now + 1'b1;
        for (int unsigned s = 0; s < n; s++) begin
            if (!hit && pg_key[s] == key) begin
                hit  = 1'b1;
                slot = s;
            end
        end
        if (!hit) begin
            if (n < cap) begin
                slot      = n;
                pg_filled = n + 1;
            end else begin
                // Pages short of K uses go first, oldest latest use; lowest slot on ties.
                found  = 1'b0;
                best   = 0;
                best_t = '0;
                for (int unsigned s = 0; s < n; s++) begin
                    if (pg_uses[s] < k) begin
                        t = pg_stamp[s][0];
                        if (!found || t < best_t) begin
                            found  = 1'b1;
                            best   = s;
                            best_t = t;
                        end
                    end
                end
                // Otherwise the page with the oldest K-th most recent use.
                if (!found) begin
                    for (int unsigned s = 0; s < n; s++) begin
                        t = pg_stamp[s][k-1];
                        if (!found || t < best_t) begin
                            found  = 1'b1;
                            best   = s;
                            best_t = t;
                        end
                    end
                end
                slot            = best;
                res.evicted     = 1'b1;
                res.evicted_key = pg_key[best];
            end
            pg_key[slot]  = key;
            pg_uses[slot] = '0;
        end
        for (int j = N_HIST - 1; j > 0; j--) begin
            pg_stamp[slot][j] = pg_stamp[slot][j-1];
        end
        pg_stamp[slot][0] = stamp_now;
        if (pg_uses[slot] < N_HIST) pg_uses[slot] = pg_uses[slot] + 3'd1;
        res.hit        = hit;
        res.slot_index = slot[SLOT_IDX_W-1:0];
    endtask

    // Monitor: mirror register writes, predict accepted items and check results.
    always @(posedge i_clk) begin
        t_rsp want;
        t_rsp got;
        req_fire = req_if.valid && req_if.ready;
        if (i_rst_n) begin
            if (i_cfg_we) apply_reg_write(i_cfg_idx, i_cfg_data);
            if (rsp_if.valid && rsp_if.ready) begin
                got = rsp_if.data;
                if (placement_q.size() == 0) begin
                    $error("unexpected result item: hit %0d slot %0d", got.hit, got.slot_index);
                    err_cnt++;
                end else begin
                    want = placement_q.pop_front();
                    if (got.hit !== want.hit) begin
                        $error("hit: expected %0d, actual %0d", want.hit, got.hit);
                        err_cnt++;
                    end
                    if (got.slot_index !== want.slot_index) begin
                        $error("slot_index: expected %0d, actual %0d",
                               want.slot_index, got.slot_index);
                        err_cnt++;
                    end
                    if (got.evicted !== want.evicted) begin
                        $error("evicted: expected %0d, actual %0d", want.evicted, got.evicted);
                        err_cnt++;
                    end
                    if (got.evicted_key !== want.evicted_key) begin
                        $error("evicted_key: expected %h, actual %h",
                               want.evicted_key, got.evicted_key);
                        err_cnt++;
                    end
                end
            end
            if (req_fire) begin
                predict_placement(req_if.data.access_key, want);
                placement_q.push_back(want);
            end
        end
    end

    // Driver: sends queued keys in bursts with random gaps between them.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else if (!req_if.valid || req_fire) begin
            if (gap_left > 0) begin
                gap_left--;
                req_if.valid <= 1'b0;
            end else if (access_q.size() > 0) begin
                req_if.valid           <= 1'b1;
                req_if.data.access_key <= access_q.pop_front();
                if (burst_left > 0) burst_left--;
                if (burst_left == 0) begin
                    if ($urandom_range(0, 7) == 0) begin
                        burst_left = $urandom_range(50, 200);
                        gap_left   = 0;
                    end else begin
                        burst_left = $urandom_range(1, 6);
                        gap_left   = $urandom_range(0, 45);
                    end
                end
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    // Receiver: switches between always ready, random stalls and long stalls.
    always @(negedge i_clk) begin
        logic rdy;
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            if (rx_span == 0) begin
                rx_mode = $urandom_range(0, 2);
                rx_span = $urandom_range(20, 300);
            end
            rx_span--;
            if (stall_left > 0) begin
                stall_left--;
                rdy = 1'b0;
            end else begin
                case (rx_mode)
                    0: rdy = 1'b1;
                    1: rdy = 1'($urandom_range(0, 1));
                    default: begin
                        if ($urandom_range(0, 15) == 0) stall_left = $urandom_range(5, 60);
                        rdy = (stall_left == 0);
                    end
                endcase
            end
            rsp_if.ready <= rdy;
        end
    end

    // Wait until every key is sent and every placement has come back.
    task automatic wait_idle();
        while (access_q.size() != 0 || req_if.valid || placement_q.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // Pulse one register write on the configuration port.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // Drain the block, let the last scan settle, then load both registers.
    task automatic set_config(input logic [CAP_W-1:0] cap, input logic [DEPTH_W-1:0] depth);
        logic [1:0] junk;
        junk = 2'($urandom_range(0, 3));
        wait_idle();
        repeat (40) @(negedge i_clk);
        write_reg(REG_CAPACITY, cap);
        write_reg(REG_DEPTH, {junk, depth});
    endtask

    // Random keys: mostly a hot pool that yields hits and full K histories,
    // some fresh keys that force misses, and the occasional extreme value.
    task automatic gen_phase(input int n_items);
        logic [KEY_W-1:0] pool[$];
        int               pool_sz, r;
        logic [KEY_W-1:0] key;
        pool_sz = cap_eff() + $urandom_range(0, cap_eff() + 2);
        for (int i = 0; i < pool_sz; i++) pool.push_back($urandom);
        for (int i = 0; i < n_items; i++) begin
            r = $urandom_range(0, 99);
            if (r < 40)      key = pool[$urandom_range(0, (pool_sz - 1) / 2)];
            else if (r < 85) key = pool[$urandom_range(0, pool_sz - 1)];
            else if (r < 97) key = $urandom;
            else             key = ($urandom_range(0, 1) != 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            access_q.push_back(key);
        end
    endtask

    // Reset, directed items, random phases, then the verdict.
    initial begin
        logic [CAP_W-1:0]   caps[10];
        logic [DEPTH_W-1:0] depths[10];
        caps         = '{16, 1, 0, 31, 16, 2, 8, 5, 12, 16};
        depths       = '{4, 1, 0, 7, 1, 4, 3, 2, 6, 2};
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = '0;
        i_cfg_data   = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Three slots, K of two: fills, hits, eviction of a page short of K uses,
        // then eviction by the K-th most recent use once every page has K uses.
        set_config(5'd3, 3'd2);
        access_q.push_back(32'h8000_0000);
        access_q.push_back(32'h7FFF_FFFF);
        access_q.push_back(32'h0000_0000);
        access_q.push_back(32'h8000_0000);
        access_q.push_back(32'hFFFF_FFFF);
        access_q.push_back(32'h0000_0000);
        access_q.push_back(32'hFFFF_FFFF);
        access_q.push_back(32'h1234_5678);
        access_q.push_back(32'h8000_0000);
        access_q.push_back(32'h7FFF_FFFF);

        // Capacity lowered to one slot drops the other pages silently.
        set_config(5'd1, 3'd1);
        access_q.push_back(32'h0000_0000);
        access_q.push_back(32'h8000_0000);
        access_q.push_back(32'h5555_5555);
        access_q.push_back(32'hAAAA_AAAA);

        // Zero capacity and zero depth act as one.
        set_config(5'd0, 3'd0);
        access_q.push_back(32'hAAAA_AAAA);
        access_q.push_back(32'h0000_0000);

        // Settings above the range act as the maximum; use counts saturate.
        set_config(5'd31, 3'd7);
        access_q.push_back(32'h0000_0001);
        access_q.push_back(32'h0000_0002);
        access_q.push_back(32'h0000_0001);
        access_q.push_back(32'h0000_0001);
        access_q.push_back(32'h0000_0001);
        access_q.push_back(32'h0000_0001);

        for (int p = 0; p < 14; p++) begin
            if (p < 10) set_config(caps[p], depths[p]);
            else        set_config(CAP_W'($urandom_range(0, 31)),
                                   DEPTH_W'($urandom_range(0, 7)));
            gen_phase(130);
        end

        wait_idle();
        repeat (60) @(negedge i_clk);
        if (err_cnt == 0 && placement_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/lrk_pkg.sv
rtl/lrk_chan_if.sv
rtl/lrk_min_track.sv
rtl/lru_k_replacement_policy_unit.sv
dv/tb_lru_k_replacement_policy_unit.sv
